// ----- sv/sst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the shader source tokenizer.
// No dependencies; every other file imports this package.
package sst_pkg;

    typedef enum logic [3:0] {
        M_IDLE,
        M_SLASH,
        M_LINE_START,
        M_LINE_SKIP,
        M_COMMAND,
        M_BLOCK,
        M_MACRO,
        M_LT,
        M_GT,
        M_BAR,
        M_AMP,
        M_EQ,
        M_BANG,
        M_LITERAL,
        M_IDENT
    } lex_mode_t;

    localparam logic [5:0] K_NEWLINE   = 6'd0;
    localparam logic [5:0] K_COMMAND   = 6'd1;
    localparam logic [5:0] K_MACRO     = 6'd2;
    localparam logic [5:0] K_COMMA     = 6'd3;
    localparam logic [5:0] K_SEMICOLON = 6'd4;
    localparam logic [5:0] K_LPAREN    = 6'd5;
    localparam logic [5:0] K_RPAREN    = 6'd6;
    localparam logic [5:0] K_LBRACKET  = 6'd7;
    localparam logic [5:0] K_RBRACKET  = 6'd8;
    localparam logic [5:0] K_LBRACE    = 6'd9;
    localparam logic [5:0] K_RBRACE    = 6'd10;
    localparam logic [5:0] K_ADD       = 6'd11;
    localparam logic [5:0] K_SUB       = 6'd12;
    localparam logic [5:0] K_MUL       = 6'd13;
    localparam logic [5:0] K_DIV       = 6'd14;
    localparam logic [5:0] K_REM       = 6'd15;
    localparam logic [5:0] K_XOR       = 6'd16;
    localparam logic [5:0] K_LTEQ      = 6'd17;
    localparam logic [5:0] K_LT        = 6'd18;
    localparam logic [5:0] K_GTEQ      = 6'd19;
    localparam logic [5:0] K_GT        = 6'd20;
    localparam logic [5:0] K_LOGIC_OR  = 6'd21;
    localparam logic [5:0] K_OR        = 6'd22;
    localparam logic [5:0] K_LOGIC_AND = 6'd23;
    localparam logic [5:0] K_AND       = 6'd24;
    localparam logic [5:0] K_EQ        = 6'd25;
    localparam logic [5:0] K_ASSIGN    = 6'd26;
    localparam logic [5:0] K_TERNARY   = 6'd27;
    localparam logic [5:0] K_COLON     = 6'd28;
    localparam logic [5:0] K_DOT       = 6'd29;
    localparam logic [5:0] K_NEQ       = 6'd30;
    localparam logic [5:0] K_LITERAL   = 6'd31;
    localparam logic [5:0] K_IDENT     = 6'd32;

    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BAR        = 8'h7C;

    // Queue between the lexer front and the result serializer.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] data;
        logic       cvalid;
        logic       tlast;
    } tok_res_t;

    // All results caused by one input word; count is 1 or 2.
    typedef struct packed {
        logic [1:0]     count;
        tok_res_t [2:0] res;
    } tok_bundle_t;

endpackage

// ----- sv/sst_front.sv -----
`timescale 1ns / 1ps
// Lexer front end: accepts one source word per cycle while the queue is not full,
// advances the lexer state and builds the bundle of results for that word. Uses sst_pkg.
module sst_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  logic [7:0]           char_in,
    input  logic                 end_of_text,
    input  logic                 q_full,
    output logic                 q_push,
    output sst_pkg::tok_bundle_t q_data
);
    import sst_pkg::*;

    typedef struct packed {
        lex_mode_t  mode;
        logic [7:0] held_char;
        logic       held_valid;
        logic       lit_suffix;
        logic       star_seen;
    } lex_state_t;

    localparam lex_state_t RESET_STATE = '{mode: M_IDLE, held_char: 8'd0,
        held_valid: 1'b0, lit_suffix: 1'b0, star_seen: 1'b0};

    lex_state_t state_reg;
    lex_state_t state_next;
    tok_res_t   slot [3];
    logic [2:0] slot_v;
    logic       do_start;
    logic       more;
    logic [5:0] text_kind;
    logic [1:0] n;
    logic       accept;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic tok_res_t mk(input logic [5:0] k, input logic [7:0] d,
                                    input logic v, input logic l);
        tok_res_t r;
        r.kind   = k;
        r.data   = v ? d : 8'd0;
        r.cvalid = v;
        r.tlast  = l;
        return r;
    endfunction

    function automatic logic [7:0] op_second(input lex_mode_t m);
        logic [7:0] r;
        unique case (m)
            M_BAR:   r = CH_BAR;
            M_AMP:   r = CH_AMP;
            default: r = CH_EQUAL;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] op_pair(input lex_mode_t m);
        logic [5:0] r;
        unique case (m)
            M_LT:    r = K_LTEQ;
            M_GT:    r = K_GTEQ;
            M_BAR:   r = K_LOGIC_OR;
            M_AMP:   r = K_LOGIC_AND;
            default: r = K_EQ;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] op_single(input lex_mode_t m);
        logic [5:0] r;
        unique case (m)
            M_LT:    r = K_LT;
            M_GT:    r = K_GT;
            M_BAR:   r = K_OR;
            M_AMP:   r = K_AND;
            default: r = K_ASSIGN;
        endcase
        return r;
    endfunction

    assign src_ready = !q_full;
    assign accept    = src_valid && src_ready;

    // Slot 0 holds what the current mode emits, slot 1 what a new token
    // start emits, slot 2 the flush at end of text.
    always_comb
    begin
        state_next = state_reg;
        slot[0]    = '0;
        slot[1]    = '0;
        slot[2]    = '0;
        slot_v     = 3'b000;
        do_start   = 1'b0;
        more       = 1'b0;
        text_kind  = (state_reg.mode == M_COMMAND) ? K_COMMAND : K_MACRO;

        unique case (state_reg.mode)
            M_SLASH:
            begin
                if (char_in == CH_SLASH)
                begin
                    state_next.mode = M_LINE_START;
                end
                else if (char_in == CH_STAR)
                begin
                    state_next.mode      = M_BLOCK;
                    state_next.star_seen = 1'b0;
                end
                else
                begin
                    slot[0]   = mk(K_DIV, 8'd0, 1'b0, 1'b1);
                    slot_v[0] = 1'b1;
                    do_start  = 1'b1;
                end
            end
            M_LINE_START:
            begin
                if (char_in == CH_BANG)
                begin
                    state_next.mode       = M_COMMAND;
                    state_next.held_valid = 1'b0;
                end
                else if (char_in == CH_LF)
                begin
                    do_start = 1'b1;
                end
                else
                begin
                    state_next.mode = M_LINE_SKIP;
                end
            end
            M_LINE_SKIP:
            begin
                do_start = (char_in == CH_LF);
            end
            M_COMMAND, M_MACRO:
            begin
                if (char_in == CH_LF)
                begin
                    slot[0] = mk(text_kind, state_reg.held_char,
                                 state_reg.held_valid, 1'b1);
                    slot_v[0]             = 1'b1;
                    state_next.held_valid = 1'b0;
                    do_start              = 1'b1;
                end
                else
                begin
                    slot[0]   = mk(text_kind, state_reg.held_char, 1'b1, 1'b0);
                    slot_v[0] = state_reg.held_valid;
                    state_next.held_char  = char_in;
                    state_next.held_valid = 1'b1;
                end
            end
            M_BLOCK:
            begin
                if (state_reg.star_seen && (char_in == CH_SLASH))
                begin
                    state_next.mode      = M_IDLE;
                    state_next.star_seen = 1'b0;
                end
                else
                begin
                    slot[0]   = mk(K_NEWLINE, 8'd0, 1'b0, 1'b1);
                    slot_v[0] = (char_in == CH_LF);
                    state_next.star_seen = (char_in == CH_STAR);
                end
            end
            M_LT, M_GT, M_BAR, M_AMP, M_EQ:
            begin
                slot_v[0] = 1'b1;
                if (char_in == op_second(state_reg.mode))
                begin
                    slot[0]         = mk(op_pair(state_reg.mode), 8'd0, 1'b0, 1'b1);
                    state_next.mode = M_IDLE;
                end
                else
                begin
                    slot[0]  = mk(op_single(state_reg.mode), 8'd0, 1'b0, 1'b1);
                    do_start = 1'b1;
                end
            end
            M_BANG:
            begin
                if (char_in == CH_EQUAL)
                begin
                    slot[0]         = mk(K_NEQ, 8'd0, 1'b0, 1'b1);
                    slot_v[0]       = 1'b1;
                    state_next.mode = M_IDLE;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            M_LITERAL, M_IDENT:
            begin
                if (state_reg.mode == M_LITERAL)
                begin
                    if (is_alpha(char_in))
                    begin
                        more                  = 1'b1;
                        state_next.lit_suffix = 1'b1;
                    end
                    else
                    begin
                        more = !state_reg.lit_suffix
                            && (is_digit(char_in) || (char_in == CH_DOT));
                    end
                end
                else
                begin
                    more = is_alpha(char_in) || is_digit(char_in)
                        || (char_in == CH_UNDERSCORE) || (char_in == CH_DOT);
                end
                slot[0] = mk((state_reg.mode == M_LITERAL) ? K_LITERAL : K_IDENT,
                             state_reg.held_char, 1'b1, !more);
                slot_v[0] = 1'b1;
                if (more)
                begin
                    state_next.held_char  = char_in;
                    state_next.held_valid = 1'b1;
                end
                else
                begin
                    state_next.held_valid = 1'b0;
                    do_start              = 1'b1;
                end
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // Start of a new token from the current character.
        if (do_start)
        begin
            state_next.mode = M_IDLE;
            slot_v[1]       = 1'b1;
            unique case (char_in)
                CH_LF:   slot[1] = mk(K_NEWLINE, 8'd0, 1'b0, 1'b1);
                ",":     slot[1] = mk(K_COMMA, 8'd0, 1'b0, 1'b1);
                ";":     slot[1] = mk(K_SEMICOLON, 8'd0, 1'b0, 1'b1);
                "(":     slot[1] = mk(K_LPAREN, 8'd0, 1'b0, 1'b1);
                ")":     slot[1] = mk(K_RPAREN, 8'd0, 1'b0, 1'b1);
                "[":     slot[1] = mk(K_LBRACKET, 8'd0, 1'b0, 1'b1);
                "]":     slot[1] = mk(K_RBRACKET, 8'd0, 1'b0, 1'b1);
                "{":     slot[1] = mk(K_LBRACE, 8'd0, 1'b0, 1'b1);
                "}":     slot[1] = mk(K_RBRACE, 8'd0, 1'b0, 1'b1);
                "+":     slot[1] = mk(K_ADD, 8'd0, 1'b0, 1'b1);
                "-":     slot[1] = mk(K_SUB, 8'd0, 1'b0, 1'b1);
                CH_STAR: slot[1] = mk(K_MUL, 8'd0, 1'b0, 1'b1);
                "%":     slot[1] = mk(K_REM, 8'd0, 1'b0, 1'b1);
                "^":     slot[1] = mk(K_XOR, 8'd0, 1'b0, 1'b1);
                "?":     slot[1] = mk(K_TERNARY, 8'd0, 1'b0, 1'b1);
                ":":     slot[1] = mk(K_COLON, 8'd0, 1'b0, 1'b1);
                CH_DOT:  slot[1] = mk(K_DOT, 8'd0, 1'b0, 1'b1);
                default:
                begin
                    slot_v[1] = 1'b0;
                    unique case (char_in)
                        CH_SLASH: state_next.mode = M_SLASH;
                        CH_HASH:
                        begin
                            state_next.mode       = M_MACRO;
                            state_next.held_valid = 1'b0;
                        end
                        "<":      state_next.mode = M_LT;
                        ">":      state_next.mode = M_GT;
                        CH_BAR:   state_next.mode = M_BAR;
                        CH_AMP:   state_next.mode = M_AMP;
                        CH_EQUAL: state_next.mode = M_EQ;
                        CH_BANG:  state_next.mode = M_BANG;
                        default:
                        begin
                            if (is_digit(char_in))
                            begin
                                state_next.mode       = M_LITERAL;
                                state_next.lit_suffix = 1'b0;
                                state_next.held_char  = char_in;
                                state_next.held_valid = 1'b1;
                            end
                            else if (is_alpha(char_in) || (char_in == CH_UNDERSCORE))
                            begin
                                state_next.mode       = M_IDENT;
                                state_next.held_char  = char_in;
                                state_next.held_valid = 1'b1;
                            end
                        end
                    endcase
                end
            endcase
        end

        // Flush whatever is pending at the end of the buffer.
        if (end_of_text)
        begin
            unique case (state_next.mode)
                M_SLASH:
                begin
                    slot[2]   = mk(K_DIV, 8'd0, 1'b0, 1'b1);
                    slot_v[2] = 1'b1;
                end
                M_COMMAND, M_MACRO, M_LITERAL, M_IDENT:
                begin
                    unique case (state_next.mode)
                        M_COMMAND: text_kind = K_COMMAND;
                        M_MACRO:   text_kind = K_MACRO;
                        M_LITERAL: text_kind = K_LITERAL;
                        default:   text_kind = K_IDENT;
                    endcase
                    slot[2] = mk(text_kind, state_next.held_char,
                                 state_next.held_valid, 1'b1);
                    slot_v[2] = 1'b1;
                end
                M_LT, M_GT, M_BAR, M_AMP, M_EQ:
                begin
                    slot[2]   = mk(op_single(state_next.mode), 8'd0, 1'b0, 1'b1);
                    slot_v[2] = 1'b1;
                end
                default:
                begin
                    slot_v[2] = 1'b0;
                end
            endcase
            state_next = RESET_STATE;
        end
    end

    // Pack the used slots in order into the bundle.
    always_comb
    begin
        n      = 2'd0;
        q_data = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (slot_v[i])
            begin
                q_data.res[n] = slot[i];
                n             = n + 2'd1;
            end
        end
        q_data.count = n;
    end

    assign q_push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RESET_STATE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/sst_queue.sv -----
`timescale 1ns / 1ps
// Short queue of result bundles between the lexer front and the serializer.
// Uses sst_pkg for the bundle type and depth.
module sst_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sst_pkg::tok_bundle_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output sst_pkg::tok_bundle_t head
);
    import sst_pkg::*;

    tok_bundle_t        mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;

    assign full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/sst_back.sv -----
`timescale 1ns / 1ps
// Result serializer: takes bundles from the queue and sends their results
// one word per cycle while tok_ready is high, through an output register. Uses sst_pkg.
module sst_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sst_pkg::tok_bundle_t q_head,
    output logic                 q_pop,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output logic [5:0]           token_kind,
    output logic [7:0]           data_char,
    output logic                 char_valid,
    output logic                 token_last,
    output logic                 run_last
);
    import sst_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    tok_res_t   res_reg;
    logic       run_last_reg;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       load;
    logic       bundle_done;

    assign load        = !q_empty && (!valid_reg || tok_ready);
    assign bundle_done = (idx_reg == (q_head.count - 2'd1));
    assign q_pop       = load && bundle_done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = bundle_done ? 2'd0 : idx_reg + 2'd1;
        end
        else if (tok_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg      <= q_head.res[idx_reg];
            run_last_reg <= bundle_done;
        end
    end

    assign tok_valid  = valid_reg;
    assign token_kind = res_reg.kind;
    assign data_char  = res_reg.data;
    assign char_valid = res_reg.cvalid;
    assign token_last = res_reg.tlast;
    assign run_last   = run_last_reg;

endmodule

// ----- sv/shader_source_tokenizer.sv -----
`timescale 1ns / 1ps
// Shader source tokenizer: one source byte per cycle in while src_ready is high,
// token results out. Each result passes through the queue and the output register.
// Throughput: one byte per cycle while each byte causes at most one result and tok_ready
// is high; a byte causing two results occupies the single output register with each in turn.
// Reset (rst_n low, asynchronous) returns the lexer to idle and empties the queue.
module shader_source_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    output logic       tok_valid,
    input  logic       tok_ready,
    output logic [5:0] token_kind,
    output logic [7:0] data_char,
    output logic       char_valid,
    output logic       token_last,
    output logic       run_last
);
    import sst_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    tok_bundle_t q_in;
    tok_bundle_t q_head;

    sst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    sst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    sst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .token_kind (token_kind),
        .data_char  (data_char),
        .char_valid (char_valid),
        .token_last (token_last),
        .run_last   (run_last)
    );

endmodule

// ----- sv/sst_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the shader source tokenizer, bound to the top level.
// Uses sst_pkg for token kind codes.
module sst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       src_valid,
    input logic       src_ready,
    input logic [7:0] char_in,
    input logic       end_of_text,
    input logic       tok_valid,
    input logic       tok_ready,
    input logic [5:0] token_kind,
    input logic [7:0] data_char,
    input logic       char_valid,
    input logic       token_last,
    input logic       run_last
);
    import sst_pkg::*;

    logic text_kind;
    assign text_kind = (token_kind == K_COMMAND) || (token_kind == K_MACRO)
        || (token_kind == K_LITERAL) || (token_kind == K_IDENT);

    // A stalled result word must stay on the port.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(token_kind)
            && $stable(data_char) && $stable(run_last))
        else $error("result word changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> token_kind <= K_IDENT)
        else $error("token kind out of range");

    // Tokens without text are single words with no character.
    a_plain_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !text_kind |-> token_last && !char_valid && (data_char == 8'd0))
        else $error("plain token carries text or spans words");

    // A token still in progress has its character present.
    a_open_token: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !token_last |-> char_valid && text_kind)
        else $error("unfinished token without a character");

    a_no_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !char_valid |-> data_char == 8'd0)
        else $error("data_char set without char_valid");

endmodule

bind shader_source_tokenizer sst_checker u_sst_checker (.*);
